// File: rtl/chtgs_pkg.sv
// Package for the chained hash table: word types, codes, state enum and defaults.
`timescale 1ns / 1ps
`default_nettype none

package chtgs_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int VALUE_WIDTH_DEF   = 32;

    // slot reduction steps: reciprocal multiply, back-multiply, correction
    localparam int MOD_STEPS = 3;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic        command;
        logic [31:0] hash;
        logic [31:0] key;
        logic [31:0] write_value;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
    } t_result_word;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_HEAD,
        ST_HEAD_CHK,
        ST_ENT_CHK,
        ST_APPEND
    } t_state;

endpackage

`default_nettype wire

// File: rtl/chained_hash_table_get_set.sv
// Top level: separate-chaining hash table with get and set over a fixed entry pool.
//
//  channel   direction  handshake                 word
//  command   in         start && !busy            i_cmd  (command, hash, key, write_value)
//  result    out        o_valid, one-cycle pulse  o_result (status, read_value)
//
// Steps: slot reduction runs through the shared multiplier (reciprocal multiply,
// back-multiply, one compare/subtract), skipped when TABLE_ENTRIES is a power of
// two. Then the head read (ST_HEAD, ST_HEAD_CHK), one read of the entry RAM port
// per chain entry visited, and an ST_APPEND step when a set appends a new entry
// behind a chain tail. The result pulses in the cycle after the last step.
// Reset: a clearing pass writes every head slot empty, with busy high. Entry
// links need no clearing: each entry is written whole when taken.
// Stalls: the receiver cannot stall; a new word may be taken in the result cycle.
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_table_get_set #(
    parameter int TABLE_ENTRIES = chtgs_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_WIDTH     = chtgs_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH   = chtgs_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    input  wire chtgs_pkg::t_cmd_word    i_cmd,
    output logic                         busy,
    output logic                         o_valid,
    output chtgs_pkg::t_result_word      o_result
);

    localparam int  IW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int  FW     = IW + 1;
    localparam int  KW     = KEY_WIDTH;
    localparam int  VW     = VALUE_WIDTH;
    localparam bit  POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam int  HEAD_W = IW + 1;
    // entry word: key | value | link valid | link index
    localparam int  ENT_W  = KW + VW + 1 + IW;
    localparam int  LV_B   = IW;
    localparam int  VAL_L  = IW + 1;
    localparam int  KEY_L  = IW + 1 + VW;
    localparam int  CW     = $clog2(chtgs_pkg::MOD_STEPS);

    localparam logic [FW-1:0]     N_F       = FW'(TABLE_ENTRIES);
    localparam logic [IW-1:0]     LAST_SLOT = IW'(TABLE_ENTRIES - 1);
    localparam logic [31:0]       SLOT_MASK = 32'(TABLE_ENTRIES - 1);
    localparam logic [31:0]       N32       = 32'(TABLE_ENTRIES);
    // floor(2^32 / TABLE_ENTRIES); quotient estimate is then low by at most one
    localparam logic [31:0]       RECIP     = 32'(64'h1_0000_0000 / 64'(TABLE_ENTRIES));
    localparam logic [CW-1:0]     LAST_STEP = CW'(chtgs_pkg::MOD_STEPS - 1);

    chtgs_pkg::t_state r_state, n_state;

    // latched command
    logic          r_cmd;
    logic [31:0]   r_hash, n_hash;
    logic [31:0]   r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_slot, n_slot;
    logic [IW-1:0] r_cur, n_cur;
    logic [FW-1:0] r_fill, n_fill;
    logic [IW-1:0] r_clr;
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;

    logic                    r_valid, n_valid;
    chtgs_pkg::t_result_word r_result, n_result;

    // memory ports
    logic              head_we, head_re;
    logic [IW-1:0]     head_waddr, head_raddr;
    logic [HEAD_W-1:0] head_wdata, head_rdata;
    logic              ent_we, ent_re;
    logic [IW-1:0]     ent_waddr, ent_raddr;
    logic [ENT_W-1:0]  ent_wdata, ent_rdata;

    // shared unit: one 32x32 multiplier, reciprocal then back-multiply
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;

    logic          accept;
    logic          is_set;
    logic          full;
    logic          head_hit;
    logic [IW-1:0] head_idx;
    logic          key_match;
    logic          link_ok;
    logic [IW-1:0] link_idx;
    logic [IW-1:0] fill_idx;
    logic [ENT_W-1:0] new_entry;

    chtgs_ram #(.WIDTH(HEAD_W), .DEPTH(TABLE_ENTRIES)) u_heads (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (head_re),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    chtgs_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_entries (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign accept    = start && !busy;
    assign is_set    = (r_cmd == chtgs_pkg::CMD_SET);
    assign full      = (r_fill == N_F);
    assign head_hit  = head_rdata[IW];
    assign head_idx  = head_rdata[IW-1:0];
    assign key_match = (ent_rdata[ENT_W-1:KEY_L] == r_key);
    assign link_ok   = ent_rdata[LV_B];
    assign link_idx  = ent_rdata[IW-1:0];
    assign fill_idx  = r_fill[IW-1:0];
    assign new_entry = {r_key, r_val, 1'b0, IW'(0)};

    // first step: hash x reciprocal; second step: quotient x table size
    assign mul_a = (r_cnt == '0) ? r_hash : r_quo;
    assign mul_b = (r_cnt == '0) ? RECIP  : N32;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chtgs_pkg::ST_CLEAR: begin
                if (r_clr == LAST_SLOT) n_state = chtgs_pkg::ST_IDLE;
            end
            chtgs_pkg::ST_IDLE: begin
                if (start) n_state = POW2 ? chtgs_pkg::ST_HEAD : chtgs_pkg::ST_MOD;
            end
            chtgs_pkg::ST_MOD: begin
                if (r_cnt == LAST_STEP) n_state = chtgs_pkg::ST_HEAD;
            end
            chtgs_pkg::ST_HEAD: begin
                n_state = chtgs_pkg::ST_HEAD_CHK;
            end
            chtgs_pkg::ST_HEAD_CHK: begin
                n_state = head_hit ? chtgs_pkg::ST_ENT_CHK : chtgs_pkg::ST_IDLE;
            end
            chtgs_pkg::ST_ENT_CHK: begin
                if (key_match) begin
                    n_state = chtgs_pkg::ST_IDLE;
                end else if (!link_ok) begin
                    n_state = (is_set && !full) ? chtgs_pkg::ST_APPEND : chtgs_pkg::ST_IDLE;
                end
            end
            chtgs_pkg::ST_APPEND: begin
                n_state = chtgs_pkg::ST_IDLE;
            end
            default: n_state = chtgs_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory controls and result
    always_comb begin
        n_hash     = r_hash;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        n_slot     = r_slot;
        n_cur      = r_cur;
        n_fill     = r_fill;
        n_valid    = 1'b0;
        n_result   = '{status: chtgs_pkg::STAT_OK, read_value: 32'd0};
        head_we    = 1'b0;
        head_waddr = r_slot;
        head_wdata = {1'b1, fill_idx};
        head_re    = 1'b0;
        head_raddr = r_slot;
        ent_we     = 1'b0;
        ent_waddr  = fill_idx;
        ent_wdata  = new_entry;
        ent_re     = 1'b0;
        ent_raddr  = head_idx;
        unique case (r_state)
            chtgs_pkg::ST_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = '0;
            end
            chtgs_pkg::ST_IDLE: begin
                n_hash = i_cmd.hash;
                n_cnt  = '0;
                n_slot = IW'(i_cmd.hash & SLOT_MASK);
            end
            chtgs_pkg::ST_MOD: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == '0) begin
                    // quotient estimate, low by at most one
                    n_quo = mul_p[63:32];
                end else if (r_cnt != LAST_STEP) begin
                    // residue below twice the table size
                    n_hash = r_hash - mul_p[31:0];
                end else begin
                    n_slot = (r_hash >= N32) ? IW'(r_hash - N32) : IW'(r_hash);
                end
            end
            chtgs_pkg::ST_HEAD: begin
                head_re = 1'b1;
            end
            chtgs_pkg::ST_HEAD_CHK: begin
                if (head_hit) begin
                    ent_re    = 1'b1;
                    ent_raddr = head_idx;
                    n_cur     = head_idx;
                end else begin
                    n_valid = 1'b1;
                    if (!is_set) begin
                        n_result.status = chtgs_pkg::STAT_MISSING;
                    end else if (full) begin
                        n_result.status = chtgs_pkg::STAT_FULL;
                    end else begin
                        // empty slot: new entry becomes the head
                        head_we = 1'b1;
                        ent_we  = 1'b1;
                        n_fill  = r_fill + FW'(1);
                    end
                end
            end
            chtgs_pkg::ST_ENT_CHK: begin
                if (key_match) begin
                    n_valid = 1'b1;
                    if (is_set) begin
                        ent_we    = 1'b1;
                        ent_waddr = r_cur;
                        ent_wdata = {ent_rdata[ENT_W-1:KEY_L], r_val, ent_rdata[IW:0]};
                    end else begin
                        n_result.read_value = 32'(ent_rdata[KEY_L-1:VAL_L]);
                    end
                end else if (link_ok) begin
                    ent_re    = 1'b1;
                    ent_raddr = link_idx;
                    n_cur     = link_idx;
                end else if (!is_set) begin
                    n_valid         = 1'b1;
                    n_result.status = chtgs_pkg::STAT_MISSING;
                end else if (full) begin
                    n_valid         = 1'b1;
                    n_result.status = chtgs_pkg::STAT_FULL;
                end else begin
                    // tail: point it at the next free entry, filled next cycle
                    ent_we    = 1'b1;
                    ent_waddr = r_cur;
                    ent_wdata = {ent_rdata[ENT_W-1:VAL_L], 1'b1, fill_idx};
                end
            end
            chtgs_pkg::ST_APPEND: begin
                ent_we  = 1'b1;
                n_fill  = r_fill + FW'(1);
                n_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chtgs_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_valid <= n_valid;
            if (r_state == chtgs_pkg::ST_CLEAR) r_clr <= r_clr + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd.command;
            r_key <= KW'(i_cmd.key);
            r_val <= VW'(i_cmd.write_value);
        end
        r_hash   <= n_hash;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_slot   <= n_slot;
        r_cur    <= n_cur;
        r_result <= n_result;
    end

    assign busy     = (r_state != chtgs_pkg::ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // one result per word, never in consecutive cycles
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= N_F)
        else $error("fill count beyond pool size");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == chtgs_pkg::STAT_FULL) |-> (r_fill == N_F))
        else $error("table full reported with free entries");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != chtgs_pkg::STAT_OK) |-> (o_result.read_value == 32'd0))
        else $error("non-zero value on failed command");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && !o_valid))
        else $error("accepted word did not start a walk");

endmodule

`default_nettype wire

// File: rtl/chtgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module chtgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: tb/chained_hash_table_get_set_tb.sv
// Self-checking bench for the chained hash table: queued get/set words, scoreboard on results.
`timescale 1ns / 1ps

module chained_hash_table_get_set_tb;

    localparam int          N            = chtgs_pkg::TABLE_ENTRIES_DEF;
    localparam logic [31:0] SLOT_MASK    = 32'(N - 1);  // N is a power of two
    localparam int          RANDOM_WORDS = 1850;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          TAIL_CYCLES  = 64;         // settle time after the last result
    localparam int          MAX_REPORTS  = 10;

    // One command word waiting to go, with its lead-in idle and an optional drain
    // (hold back until every outstanding result has come home).
    typedef struct {
        chtgs_pkg::t_cmd_word word;
        int unsigned          gap;
        bit                   drain;
    } t_pending;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start   = 1'b0;
    chtgs_pkg::t_cmd_word    i_cmd   = '0;
    logic                    busy;
    logic                    o_valid;
    chtgs_pkg::t_result_word o_result;

    t_pending                command_words[$];
    chtgs_pkg::t_result_word expected_results[$];

    // Mirror of the table: head slots, entry pool and fill level
    logic        head_used [N];
    logic [10:0] head_at   [N];
    logic [31:0] ent_key   [N];
    logic [31:0] ent_val   [N];
    logic        link_used [N];
    logic [10:0] link_at   [N];
    int unsigned used_entries;

    int unsigned total_words;
    int unsigned words_sent;
    int unsigned results_seen;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned n_get, n_set, n_ok, n_missing, n_full;

    chained_hash_table_get_set dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: walks the mirrored chain exactly as the block should and
    // applies any insert/replace, returning the result word due.
    // ------------------------------------------------------------------
    function automatic chtgs_pkg::t_result_word hash_table_access(chtgs_pkg::t_cmd_word w);
        chtgs_pkg::t_result_word r;
        int unsigned  slot;
        int unsigned  cur;
        int unsigned  steps;
        bit           walking;
        bit           hit;
        r.status     = chtgs_pkg::STAT_OK;
        r.read_value = '0;
        slot    = w.hash % N;
        cur     = 32'(head_at[slot]);
        steps   = 0;
        hit     = 1'b0;
        walking = head_used[slot];
        // walk is capped at N steps; the block itself follows links with no cap
        while (walking) begin
            if (ent_key[cur] == w.key) begin
                hit     = 1'b1;
                walking = 1'b0;
            end else begin
                steps++;
                if (!link_used[cur] || steps >= N)
                    walking = 1'b0;
                else
                    cur = 32'(link_at[cur]);
            end
        end
        if (w.command == chtgs_pkg::CMD_GET) begin
            if (hit)
                r.read_value = ent_val[cur];
            else
                r.status = chtgs_pkg::STAT_MISSING;
        end else if (hit) begin
            // replace in place; allowed even with the pool full
            ent_val[cur] = w.write_value;
        end else if (used_entries >= N) begin
            r.status = chtgs_pkg::STAT_FULL;
        end else begin
            ent_key[used_entries]   = w.key;
            ent_val[used_entries]   = w.write_value;
            link_used[used_entries] = 1'b0;
            if (head_used[slot]) begin
                link_used[cur] = 1'b1;
                link_at[cur]   = 11'(used_entries);
            end else begin
                head_used[slot] = 1'b1;
                head_at[slot]   = 11'(used_entries);
            end
            used_entries++;
        end
        return r;
    endfunction

    task automatic add_word(input logic cmd, input logic [31:0] h, input logic [31:0] k,
                            input logic [31:0] v, input int unsigned gap, input bit drain);
        t_pending p;
        p.word.command     = cmd;
        p.word.hash        = h;
        p.word.key         = k;
        p.word.write_value = v;
        p.gap              = gap;
        p.drain            = drain;
        command_words.push_back(p);
    endtask

    // ------------------------------------------------------------------
    // Driver: a word is taken on an edge with start high and busy low.
    // start stays high across back-to-back words, so it gets at most one NBA per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        chtgs_pkg::t_result_word r;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cmd <= '0;
        end else begin
            if (start && !busy) begin
                r = hash_table_access(i_cmd);
                expected_results.push_back(r);
                words_sent++;
                if (i_cmd.command == chtgs_pkg::CMD_GET) n_get++; else n_set++;
                case (r.status)
                    chtgs_pkg::STAT_OK:      n_ok++;
                    chtgs_pkg::STAT_MISSING: n_missing++;
                    default:                 n_full++;
                endcase
            end
            if (start && busy) begin
                // word still on offer; hold
            end else if (command_words.size() == 0) begin
                start <= 1'b0;
            end else if (command_words[0].gap > 0) begin
                command_words[0].gap = command_words[0].gap - 1;
                start <= 1'b0;
            end else if (command_words[0].drain && expected_results.size() != 0) begin
                start <= 1'b0;
            end else begin
                i_cmd <= command_words[0].word;
                start <= 1'b1;
                void'(command_words.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: result words last one cycle; compare against the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        chtgs_pkg::t_result_word want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result word: status %0d value %08h",
                             $realtime, o_result.status, o_result.read_value);
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status ||
                    o_result.read_value !== want.read_value) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] result %0d: status exp %0d got %0d, %s %08h got %08h",
                                 $realtime, results_seen, want.status, o_result.status,
                                 "value exp", want.read_value, o_result.read_value);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus build, reset, end of run
    // ------------------------------------------------------------------
    initial begin : main
        logic [31:0] known_hash[$];
        logic [31:0] known_key[$];
        logic [31:0] h;
        logic [31:0] k;
        int unsigned fresh_sets;
        int unsigned pick;
        int unsigned sel;
        int unsigned idx;
        int unsigned gap;
        bit          quiet;
        bit          drain;
        bit          full_phase;

        for (int i = 0; i < N; i++) begin
            head_used[i] = 1'b0;
            head_at[i]   = '0;
            ent_key[i]   = '0;
            ent_val[i]   = '0;
            link_used[i] = 1'b0;
            link_at[i]   = '0;
        end
        used_entries = 0;
        words_sent   = 0;
        results_seen = 0;
        fail_count   = 0;
        cycle_count  = 0;
        n_get = 0; n_set = 0; n_ok = 0; n_missing = 0; n_full = 0;

        // Directed: empty table, chain of three in slot 0, replace, other slots,
        // extremes of hash/key/value, get ignoring its write value
        add_word(chtgs_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b0);
        add_word(chtgs_pkg::CMD_SET, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b0);
        add_word(chtgs_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_word(chtgs_pkg::CMD_SET, 32'h0000_0400, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        add_word(chtgs_pkg::CMD_SET, 32'hFFFF_FC00, 32'h1234_5678, 32'hA5A5_A5A5, 0, 1'b0);
        add_word(chtgs_pkg::CMD_GET, 32'h0000_0400, 32'h1234_5678, 32'h0000_0000, 0, 1'b0);
        add_word(chtgs_pkg::CMD_GET, 32'h0000_0000, 32'hDEAD_BEEF, 32'h0000_0000, 0, 1'b0);
        add_word(chtgs_pkg::CMD_SET, 32'h0000_0000, 32'h0000_0000, 32'h5A5A_5A5A, 0, 1'b0);
        add_word(chtgs_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_word(chtgs_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_word(chtgs_pkg::CMD_SET, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 0, 1'b0);
        add_word(chtgs_pkg::CMD_GET, 32'h0000_03FF, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_word(chtgs_pkg::CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        add_word(chtgs_pkg::CMD_SET, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
        add_word(chtgs_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        add_word(chtgs_pkg::CMD_GET, 32'h0000_0000, 32'h1234_5678, 32'hFFFF_FFFF, 0, 1'b0);
        add_word(chtgs_pkg::CMD_SET, 32'h0000_0200, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_word(chtgs_pkg::CMD_GET, 32'h0000_0200, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        known_hash = '{32'h0000_0000, 32'h0000_0400, 32'hFFFF_FC00, 32'hFFFF_FFFF, 32'h0000_0200};
        known_key  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000};
        fresh_sets = 5;

        // Random: fill the pool (some keys forced onto a few hot slots for long
        // chains), then keep hammering it once full
        quiet = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 150 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (quiet || pick < 60)
                gap = 0;
            else if (pick < 93)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(10, 60);
            // first random word waits for the directed part to drain
            drain      = (n == 0) || ($urandom_range(0, 99) == 0);
            full_phase = (fresh_sets >= N);
            pick       = $urandom_range(0, 99);
            if (pick < (full_phase ? 30 : 60)) begin
                if ($urandom_range(0, 4) == 0)
                    h = ($urandom & ~SLOT_MASK) | ($urandom_range(0, 15) * 61);
                else
                    h = $urandom;
                k = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63) : $urandom;
                known_hash.push_back(h);
                known_key.push_back(k);
                fresh_sets++;
                add_word(chtgs_pkg::CMD_SET, h, k, $urandom, gap, drain);
            end else if (pick < (full_phase ? 55 : 72)) begin
                // rewrite a known key through a hash that lands on the same slot
                idx = $urandom_range(0, known_key.size() - 1);
                h   = known_hash[idx] ^ ($urandom & ~SLOT_MASK);
                add_word(chtgs_pkg::CMD_SET, h, known_key[idx], $urandom, gap, drain);
            end else begin
                idx = $urandom_range(0, known_key.size() - 1);
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    h = known_hash[idx];
                    k = known_key[idx];
                end else if (sel < 75) begin
                    h = known_hash[idx] ^ ($urandom & ~SLOT_MASK);
                    k = known_key[idx];
                end else if (sel < 85) begin
                    h = $urandom;
                    k = known_key[idx];
                end else begin
                    h = $urandom;
                    k = $urandom;
                end
                add_word(chtgs_pkg::CMD_GET, h, k, $urandom, gap, drain);
            end
        end
        total_words = command_words.size();

        // Reset held low from time zero and then released; the block then clears its
        // head slots with busy high before taking the first word
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_sent < total_words)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d gets, %0d sets), checked %0d results, pool at %0d of %0d",
                 words_sent, n_get, n_set, results_seen, used_entries, N);
        $display("Outcomes: %0d success, %0d key missing, %0d table full; %0d failures",
                 n_ok, n_missing, n_full, fail_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/chtgs_pkg.sv
rtl/chtgs_ram.sv
rtl/chained_hash_table_get_set.sv
tb/chained_hash_table_get_set_tb.sv
